>>> hw/rtl/twts_pkg.sv
// ---------------------------------------------------------------------------
// twts_pkg
// Shared types, field layout and helpers for the two-way time sync unit.
// ---------------------------------------------------------------------------
package twts_pkg;

	localparam int TS_W   = 63;
	localparam int OFS_W  = 64;
	localparam int ZONE_W = 17;
	localparam int ZNS_W  = 48;
	localparam int SUM_W  = 66;
	localparam int OP_W   = 2;

	// input beat layout
	localparam int IN_CS_LSB   = 0;
	localparam int IN_CR_LSB   = IN_CS_LSB + TS_W;
	localparam int IN_SR_LSB   = IN_CR_LSB + TS_W;
	localparam int IN_ST_LSB   = IN_SR_LSB + TS_W;
	localparam int IN_ZONE_LSB = IN_ST_LSB + TS_W;
	localparam int IN_NOW_LSB  = IN_ZONE_LSB + ZONE_W;
	localparam int IN_USED     = IN_NOW_LSB + TS_W;
	localparam int IN_W        = ((IN_USED + 7) / 8) * 8;

	// output beat layout
	localparam int OUT_RT_LSB   = 0;
	localparam int OUT_OFS_LSB  = OUT_RT_LSB + TS_W;
	localparam int OUT_UTC_LSB  = OUT_OFS_LSB + OFS_W;
	localparam int OUT_LOC_LSB  = OUT_UTC_LSB + TS_W;
	localparam int OUT_SYNC_BIT = OUT_LOC_LSB + TS_W;
	localparam int OUT_USED     = OUT_SYNC_BIT + 1;
	localparam int OUT_W        = ((OUT_USED + 7) / 8) * 8;

	localparam logic [TS_W-1:0]  TS_MAX   = {TS_W{1'b1}};
	localparam logic signed [30:0] NS_PER_S = 31'sd1000000000;

	typedef enum logic [OP_W-1:0] {
		OP_SYNC  = 2'd0,
		OP_QUERY = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// clamp a signed wide sum into [0, 2^63-1]
	function automatic logic [TS_W-1:0] clamp63(input logic signed [SUM_W-1:0] v);
		logic [TS_W-1:0] r;
		if (v[SUM_W-1]) begin
			r = '0;
		end else if (|v[SUM_W-2:TS_W]) begin
			r = TS_MAX;
		end else begin
			r = v[TS_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/two_way_time_sync_offset_top.sv
// ---------------------------------------------------------------------------
// two_way_time_sync_offset_top
// Two-way time transfer: keeps clock offset, round trip and zone offset,
// converts monotonic time to UTC and local time on query.
// ---------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  s_*     | in  | cli_tx, cli_rx, srv_rx, srv_tx, zone,  | op
//          |     | monotonic now                          |
//  m_*     | out | round trip, offset, utc, local, synced | -
//
//  Three register stages: input, state/UTC, local time/output.
//  One beat per cycle while m_tready is high; m_tvalid is the output stage valid.
//  State is updated as a beat leaves the input stage, so the next beat sees it.
//  A stage advances when the one after it is empty or moving.
//  arst_n clears state and all valid flags.
// ---------------------------------------------------------------------------
module two_way_time_sync_offset_top import twts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// client_send_ns, client_receive_ns, server_receive_ns, server_transmit_ns,
	// zone_offset_s, monotonic_now_ns, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	// op
	input  logic [OP_W-1:0]  s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// round_trip_ns, offset_ns, utc_now_ns, local_now_ns, synced, zero pad
	output logic [OUT_W-1:0] m_tdata
);

	logic v_s1, v_s2, v_s3;
	logic move1, move2, fire_in, go1, go2;

	logic [OP_W-1:0]          op_s1;
	logic [TS_W-1:0]          cs_s1, cr_s1, sr_s1, st_s1, now_s1;
	logic signed [ZONE_W-1:0] zone_s1;

	logic signed [OFS_W-1:0]  off_q;
	logic [TS_W-1:0]          rt_q;
	logic signed [ZNS_W-1:0]  zns_q;
	logic                     sync_q;

	logic signed [OFS_W-1:0]  off_nxt;
	logic [TS_W-1:0]          rt_nxt;
	logic signed [ZNS_W-1:0]  zns_nxt;
	logic                     sync_nxt;

	logic signed [SUM_W-1:0]  off_sum, off_adj, rt_sum, utc_sum, loc_sum;
	logic signed [OFS_W-1:0]  off_new;
	logic [TS_W-1:0]          rt_new, utc_new, loc_new;
	logic signed [ZNS_W-1:0]  zns_new;

	logic [TS_W-1:0]          rt_s2, utc_s2;
	logic signed [OFS_W-1:0]  off_s2;
	logic signed [ZNS_W-1:0]  zns_s2;
	logic                     sync_s2;

	logic [TS_W-1:0]          rt_s3, utc_s3, loc_s3;
	logic signed [OFS_W-1:0]  off_s3;
	logic                     sync_s3;

	assign move2    = !v_s3 || m_tready;
	assign move1    = !v_s2 || move2;
	assign s_tready = !v_s1 || move1;
	assign fire_in  = s_tvalid && s_tready;
	assign go1      = v_s1 && move1;
	assign go2      = v_s2 && move2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= fire_in || (v_s1 && !move1);
			v_s2 <= go1 || (v_s2 && !move2);
			v_s3 <= go2 || (v_s3 && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (fire_in) begin
			op_s1   <= s_tuser;
			cs_s1   <= s_tdata[IN_CS_LSB +: TS_W];
			cr_s1   <= s_tdata[IN_CR_LSB +: TS_W];
			sr_s1   <= s_tdata[IN_SR_LSB +: TS_W];
			st_s1   <= s_tdata[IN_ST_LSB +: TS_W];
			zone_s1 <= s_tdata[IN_ZONE_LSB +: ZONE_W];
			now_s1  <= s_tdata[IN_NOW_LSB +: TS_W];
		end
	end

	// offset: halved sum, truncated toward zero
	assign off_sum = $signed({3'b0, sr_s1}) + $signed({3'b0, st_s1})
		- $signed({3'b0, cs_s1}) - $signed({3'b0, cr_s1});
	assign off_adj = off_sum + $signed({{(SUM_W-1){1'b0}}, off_sum[SUM_W-1]});
	assign off_new = off_adj[OFS_W:1];

	assign rt_sum = $signed({3'b0, cr_s1}) + $signed({3'b0, sr_s1})
		- $signed({3'b0, cs_s1}) - $signed({3'b0, st_s1});
	assign rt_new = clamp63(rt_sum);

	assign zns_new = $signed({{(ZNS_W-ZONE_W){zone_s1[ZONE_W-1]}}, zone_s1})
		* ZNS_W'(NS_PER_S);

	assign utc_sum = $signed({3'b0, now_s1}) + $signed({{(SUM_W-OFS_W){off_q[OFS_W-1]}}, off_q});
	assign utc_new = (op_s1 == OP_QUERY && sync_q) ? clamp63(utc_sum) : '0;

	always_comb begin
		off_nxt  = off_q;
		rt_nxt   = rt_q;
		zns_nxt  = zns_q;
		sync_nxt = sync_q;
		case (op_s1)
			OP_SYNC: begin
				off_nxt  = off_new;
				rt_nxt   = rt_new;
				zns_nxt  = zns_new;
				sync_nxt = 1'b1;
			end
			OP_CLEAR: begin
				off_nxt  = '0;
				rt_nxt   = '0;
				zns_nxt  = '0;
				sync_nxt = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			rt_q   <= '0;
			zns_q  <= '0;
			sync_q <= 1'b0;
		end else if (go1) begin
			off_q  <= off_nxt;
			rt_q   <= rt_nxt;
			zns_q  <= zns_nxt;
			sync_q <= sync_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			rt_s2   <= rt_nxt;
			off_s2  <= off_nxt;
			sync_s2 <= sync_nxt;
			utc_s2  <= utc_new;
			zns_s2  <= zns_q;
		end
	end

	assign loc_sum = $signed({3'b0, utc_s2})
		+ $signed({{(SUM_W-ZNS_W){zns_s2[ZNS_W-1]}}, zns_s2});
	assign loc_new = (utc_s2 == '0) ? '0 : clamp63(loc_sum);

	always_ff @(posedge clk) begin
		if (go2) begin
			rt_s3   <= rt_s2;
			off_s3  <= off_s2;
			utc_s3  <= utc_s2;
			loc_s3  <= loc_new;
			sync_s3 <= sync_s2;
		end
	end

	assign m_tvalid = v_s3;
	assign m_tdata  = {{(OUT_W-OUT_USED){1'b0}}, sync_s3, loc_s3, utc_s3, off_s3, rt_s3};

`ifndef NO_ASSERTIONS
	a_unsynced_state_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!sync_q |-> (off_q == '0 && rt_q == '0 && zns_q == '0))
		else $error("stored values nonzero while unsynced");

	a_utc_needs_sync: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !sync_s3 |-> utc_s3 == '0)
		else $error("utc reported while unsynced");

	a_local_needs_utc: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && utc_s3 == '0 |-> loc_s3 == '0)
		else $error("local time without utc");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!go1 |=> $stable(off_q) && $stable(sync_q))
		else $error("state changed without a beat");
`endif

endmodule
